### hw/rtl/sppc_pkg.sv
// Shared types, codes and constants of the stepper pulse/position controller.
// Used by the period divider, the top level and the port checker; no dependencies.
package sppc_pkg;

    // Default parameter values.
    localparam int MOTOR_COUNT_DEF = 3;
    localparam int PERIOD_BITS_DEF = 16;

    // Fixed field widths.
    localparam int OP_W    = 3;
    localparam int MOTOR_W = 2;
    localparam int POS_W   = 32;
    localparam int VEL_W   = 21;
    localparam int RATE_W  = 24;
    localparam int IPER_W  = 16;
    localparam int MODE_W  = 2;
    localparam int DIR_W   = 2;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 24;

    // Configuration register indexes and their reset values.
    localparam logic [CIDX_W-1:0] CFG_TICK_RATE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INIT_PERIOD = 2'd1;
    localparam logic [RATE_W-1:0] TICK_RATE_RST   = 24'd1000000;
    localparam logic [IPER_W-1:0] INIT_PERIOD_RST = 16'd999;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_POS = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_PV  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_VEL = 3'd3;
    localparam logic [OP_W-1:0] OP_ZERO    = 3'd4;
    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd5;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd6;

    // Run modes.
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VEL  = 2'd2;

    // Step directions, two-bit signed.
    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;

    // Status of the period divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### hw/rtl/sppc_period_div.sv
// Bit-serial restoring divider that turns tick_rate / |velocity| into a step period.
// Depends on sppc_pkg for widths and the status struct.
module sppc_period_div #(
    parameter int PERIOD_BITS = sppc_pkg::PERIOD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [sppc_pkg::RATE_W-1:0]      tick_rate,
    input  logic [sppc_pkg::VEL_W-1:0]       velocity,
    output sppc_pkg::div_status_t            status,
    output logic [PERIOD_BITS-1:0]           period
);

    localparam int QW = sppc_pkg::RATE_W;
    localparam int VW = sppc_pkg::VEL_W;
    localparam int CW = $clog2(QW);
    localparam logic [32:0] PMAX = (33'd1 << PERIOD_BITS) - 33'd1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] mag_reg, mag_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [QW-1:0] dq_reg, dq_next;

    logic [VW-1:0] mag_in;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;
    logic [QW-1:0] qm1;
    logic          sat;

    // The magnitude of the most negative velocity still fits as unsigned.
    assign mag_in  = velocity[VW-1] ? (VW'(0) - velocity) : velocity;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, dq_reg[QW-1]};
    assign diff    = shifted - {1'b0, mag_reg};
    assign ge      = shifted >= {1'b0, mag_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW - 1);
            mag_next  = mag_in;
            rem_next  = '0;
            dq_next   = tick_rate;
        end else if (busy_reg) begin
            rem_next = ge ? diff[VW-1:0] : shifted[VW-1:0];
            dq_next  = {dq_reg[QW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    // Period is quotient minus one, floored at zero and saturated at the counter range.
    assign qm1 = (dq_reg == '0) ? '0 : (dq_reg - QW'(1));
    assign sat = {{(33 - QW){1'b0}}, qm1} > PMAX;

    always_comb begin
        period      = sat ? '1 : PERIOD_BITS'(qm1);
        status.busy = busy_reg;
        status.done = done_reg;
    end

endmodule

### hw/rtl/stepper_pulse_position_controller.sv
// A tick beat walks the motors one per cycle and then registers its result.
// A velocity command that sets a new period first passes through the 24-step divider.
// All other commands are applied in EXEC and then registered as a result.
// One beat is worked on at a time; the next is taken only after the result is registered.
// Reset (aresetn, synchronous, active low) restores control, config and motor state registers.
module stepper_pulse_position_controller #(
    parameter int MOTOR_COUNT = sppc_pkg::MOTOR_COUNT_DEF,
    parameter int PERIOD_BITS = sppc_pkg::PERIOD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sppc_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [sppc_pkg::CDAT_W-1:0]      cfg_data,

    // Command channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sppc_pkg::OP_W-1:0]        s_opcode,
    input  logic [sppc_pkg::MOTOR_W-1:0]     s_motor,
    input  logic signed [sppc_pkg::POS_W-1:0] s_target_position,
    input  logic signed [sppc_pkg::VEL_W-1:0] s_velocity,
    input  logic                             s_enable_flag,

    // Status channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sppc_pkg::MOTOR_W-1:0]     m_report_motor,
    output logic signed [sppc_pkg::POS_W-1:0] m_position,
    output logic signed [sppc_pkg::VEL_W-1:0] m_speed,
    output logic [sppc_pkg::MODE_W-1:0]      m_mode,
    output logic signed [sppc_pkg::DIR_W-1:0] m_direction,
    output logic [MOTOR_COUNT-1:0]           m_step_pins,
    output logic [MOTOR_COUNT-1:0]           m_dir_pins,
    output logic [MOTOR_COUNT-1:0]           m_enable_pins,
    output logic [MOTOR_COUNT-1:0]           m_step_events
);

    localparam int MIW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int PW  = PERIOD_BITS;
    localparam int XW  = sppc_pkg::POS_W;
    localparam int VW  = sppc_pkg::VEL_W;
    localparam logic [32:0] PMAX = (33'd1 << PERIOD_BITS) - 33'd1;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_TICK = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [sppc_pkg::RATE_W-1:0] rate_reg;
    logic [sppc_pkg::IPER_W-1:0] iper_reg;

    // The beat being worked on.
    logic [sppc_pkg::OP_W-1:0]    op_reg;
    logic [sppc_pkg::MOTOR_W-1:0] mot_reg;
    logic [XW-1:0]                tpos_reg;
    logic [VW-1:0]                vel_reg;
    logic                         en_reg;

    // Per-motor state.
    logic [XW-1:0]               pos_reg  [MOTOR_COUNT];
    logic [XW-1:0]               goal_reg [MOTOR_COUNT];
    logic [VW-1:0]               vst_reg  [MOTOR_COUNT];
    logic [sppc_pkg::MODE_W-1:0] mode_reg [MOTOR_COUNT];
    logic [sppc_pkg::DIR_W-1:0]  dir_reg  [MOTOR_COUNT];
    logic [PW-1:0]               per_reg  [MOTOR_COUNT];
    logic [PW-1:0]               cnt_reg  [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0]      drv_reg;
    logic [MOTOR_COUNT-1:0]      run_reg;
    logic [MOTOR_COUNT-1:0]      pset_reg;
    logic [MOTOR_COUNT-1:0]      dlev_reg;

    // Sequencer bookkeeping.
    logic                   have_reg, have_next;
    logic [MIW-1:0]         tk_reg, tk_next;
    logic [MOTOR_COUNT-1:0] events_reg, events_next;

    // Result register.
    logic                        m_valid_reg, m_valid_next;
    logic [sppc_pkg::MOTOR_W-1:0] m_motor_reg;
    logic [XW-1:0]               m_pos_reg;
    logic [VW-1:0]               m_speed_reg;
    logic [sppc_pkg::MODE_W-1:0] m_mode_reg;
    logic [sppc_pkg::DIR_W-1:0]  m_dir_reg;
    logic [MOTOR_COUNT-1:0]      m_steps_reg;
    logic [MOTOR_COUNT-1:0]      m_dirs_reg;
    logic [MOTOR_COUNT-1:0]      m_ens_reg;
    logic [MOTOR_COUNT-1:0]      m_events_reg;

    // Selected motor and its fields.
    logic [MIW-1:0]              mi;
    logic                        mot_ok;
    logic [MIW-1:0]              sel;
    logic [XW-1:0]               c_pos, c_goal;
    logic [VW-1:0]               c_vel;
    logic [sppc_pkg::MODE_W-1:0] c_mode;
    logic [sppc_pkg::DIR_W-1:0]  c_dir;
    logic [PW-1:0]               c_per, c_cnt, c_eff;
    logic                        c_drv, c_run, c_pset, c_dlev;

    // Next values of the selected motor's entry.
    logic [XW-1:0]               pos_next, goal_next;
    logic [VW-1:0]               vst_next;
    logic [sppc_pkg::MODE_W-1:0] mode_next;
    logic [sppc_pkg::DIR_W-1:0]  dir_next;
    logic [PW-1:0]               per_next, cnt_next;
    logic                        drv_next, run_next, pset_next, dlev_next;

    logic                        wr_en;
    logic                        out_load;
    logic                        tick_event;
    logic                        need_div;
    logic                        div_start;
    logic [XW-1:0]               step_pos;
    logic                        tpos_ne, vel_nz, aim_fwd;
    logic [PW-1:0]               init_eff;
    logic [MOTOR_COUNT-1:0]      steps_w;
    sppc_pkg::div_status_t       div_status;
    logic [PW-1:0]               div_period;

    // ------------------------------------------------------------------
    // Configuration. Writes must arrive only while the block is idle, which
    // is not enforced. The port is always ready. Unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= sppc_pkg::TICK_RATE_RST;
            iper_reg <= sppc_pkg::INIT_PERIOD_RST;
        end else if (cfg_valid) begin
            if (cfg_index == sppc_pkg::CFG_TICK_RATE) begin
                rate_reg <= cfg_data;
            end else if (cfg_index == sppc_pkg::CFG_INIT_PERIOD) begin
                iper_reg <= cfg_data[sppc_pkg::IPER_W-1:0];
            end
        end
    end

    // The initial period is clamped to the counter range, in case the
    // counter is narrower than the register.
    assign init_eff = ({17'b0, iper_reg} > PMAX) ? '1 : PW'(iper_reg);

    // ------------------------------------------------------------------
    // Period divider: tick_rate / |velocity|, one quotient bit per cycle.
    // ------------------------------------------------------------------
    sppc_period_div #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .tick_rate (rate_reg),
        .velocity  (vel_reg),
        .status    (div_status),
        .period    (div_period)
    );

    // ------------------------------------------------------------------
    // Input capture.
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_opcode;
            mot_reg  <= s_motor;
            tpos_reg <= s_target_position;
            vel_reg  <= s_velocity;
            en_reg   <= s_enable_flag;
        end
    end

    // A non-tick command to a motor that does not exist changes nothing and
    // reports zeros for that motor's status.
    assign mot_ok = {2'b00, mot_reg} < 4'(MOTOR_COUNT);
    assign mi     = MIW'(mot_reg);

    // During a tick the sequencer walks the motors; otherwise the
    // addressed motor is selected.
    assign sel    = (state_reg == ST_TICK) ? tk_reg : mi;

    assign c_pos  = pos_reg[sel];
    assign c_goal = goal_reg[sel];
    assign c_vel  = vst_reg[sel];
    assign c_mode = mode_reg[sel];
    assign c_dir  = dir_reg[sel];
    assign c_per  = per_reg[sel];
    assign c_cnt  = cnt_reg[sel];
    assign c_drv  = drv_reg[sel];
    assign c_run  = run_reg[sel];
    assign c_pset = pset_reg[sel];
    assign c_dlev = dlev_reg[sel];
    assign c_eff  = c_pset ? c_per : init_eff;

    assign step_pos = c_pos + {{(XW - sppc_pkg::DIR_W){c_dir[sppc_pkg::DIR_W-1]}}, c_dir};
    assign tpos_ne  = (tpos_reg != c_pos);
    assign vel_nz   = (vel_reg != '0);
    assign aim_fwd  = $signed(tpos_reg) > $signed(c_pos);

    // A new period is needed by a nonzero set-velocity, and by a nonzero
    // set-position-with-velocity whose target differs from the position.
    assign need_div = mot_ok && vel_nz &&
                      ((op_reg == sppc_pkg::OP_SET_VEL) ||
                       ((op_reg == sppc_pkg::OP_SET_PV) && tpos_ne));

    // ------------------------------------------------------------------
    // Motor update: the new value of the selected motor's entry.
    // ------------------------------------------------------------------
    always_comb begin
        pos_next   = c_pos;
        goal_next  = c_goal;
        vst_next   = c_vel;
        mode_next  = c_mode;
        dir_next   = c_dir;
        per_next   = c_per;
        cnt_next   = c_cnt;
        drv_next   = c_drv;
        run_next   = c_run;
        pset_next  = c_pset;
        dlev_next  = c_dlev;
        tick_event = 1'b0;

        if (state_reg == ST_TICK) begin
            // The counter runs 0..period and then wraps; each wrap is a step.
            if (c_run) begin
                if (c_cnt < c_eff) begin
                    cnt_next = c_cnt + PW'(1);
                end else begin
                    cnt_next   = '0;
                    pos_next   = step_pos;
                    tick_event = 1'b1;
                    if (c_mode == sppc_pkg::MODE_POS) begin
                        // Stop on the goal; turn around on an overshoot.
                        if (step_pos == c_goal) begin
                            run_next  = 1'b0;
                            mode_next = sppc_pkg::MODE_IDLE;
                        end else if ((c_dir == sppc_pkg::DIR_FWD) &&
                                     ($signed(step_pos) > $signed(c_goal))) begin
                            dir_next  = sppc_pkg::DIR_REV;
                            dlev_next = 1'b0;
                        end else if ((c_dir == sppc_pkg::DIR_REV) &&
                                     ($signed(step_pos) < $signed(c_goal))) begin
                            dir_next  = sppc_pkg::DIR_FWD;
                            dlev_next = 1'b1;
                        end
                    end
                end
            end
        end else begin
            unique case (op_reg)
                sppc_pkg::OP_SET_POS: begin
                    drv_next  = 1'b1;
                    goal_next = tpos_reg;
                    if (tpos_ne) begin
                        dir_next  = aim_fwd ? sppc_pkg::DIR_FWD : sppc_pkg::DIR_REV;
                        dlev_next = aim_fwd;
                        run_next  = 1'b1;
                        mode_next = sppc_pkg::MODE_POS;
                    end
                end
                sppc_pkg::OP_SET_PV: begin
                    drv_next  = 1'b1;
                    vst_next  = vel_reg;
                    goal_next = tpos_reg;
                    if (!vel_nz) begin
                        mode_next = sppc_pkg::MODE_IDLE;
                        dir_next  = sppc_pkg::DIR_NONE;
                        run_next  = 1'b0;
                    end else if (tpos_ne) begin
                        per_next  = div_period;
                        pset_next = 1'b1;
                        dir_next  = aim_fwd ? sppc_pkg::DIR_FWD : sppc_pkg::DIR_REV;
                        dlev_next = aim_fwd;
                        run_next  = 1'b1;
                        mode_next = sppc_pkg::MODE_POS;
                    end
                end
                sppc_pkg::OP_SET_VEL: begin
                    drv_next = 1'b1;
                    vst_next = vel_reg;
                    if (!vel_nz) begin
                        mode_next = sppc_pkg::MODE_IDLE;
                        dir_next  = sppc_pkg::DIR_NONE;
                        run_next  = 1'b0;
                    end else begin
                        dir_next  = vel_reg[VW-1] ? sppc_pkg::DIR_REV : sppc_pkg::DIR_FWD;
                        dlev_next = !vel_reg[VW-1];
                        mode_next = sppc_pkg::MODE_VEL;
                        per_next  = div_period;
                        pset_next = 1'b1;
                        run_next  = 1'b1;
                    end
                end
                sppc_pkg::OP_ZERO: begin
                    drv_next  = 1'b1;
                    vst_next  = '0;
                    mode_next = sppc_pkg::MODE_IDLE;
                    dir_next  = sppc_pkg::DIR_NONE;
                    run_next  = 1'b0;
                    pos_next  = '0;
                end
                sppc_pkg::OP_ENABLE: begin
                    // Disabling only releases the enable pin; stepping goes on.
                    drv_next = en_reg;
                end
                default: begin
                    // Query and the unused opcode leave the motor alone.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                pos_reg[k]  <= '0;
                goal_reg[k] <= '0;
                vst_reg[k]  <= '0;
                mode_reg[k] <= sppc_pkg::MODE_IDLE;
                dir_reg[k]  <= sppc_pkg::DIR_FWD;
                per_reg[k]  <= '0;
                cnt_reg[k]  <= '0;
            end
            drv_reg  <= '0;
            run_reg  <= '0;
            pset_reg <= '0;
            dlev_reg <= '1;
        end else if (wr_en) begin
            pos_reg[sel]  <= pos_next;
            goal_reg[sel] <= goal_next;
            vst_reg[sel]  <= vst_next;
            mode_reg[sel] <= mode_next;
            dir_reg[sel]  <= dir_next;
            per_reg[sel]  <= per_next;
            cnt_reg[sel]  <= cnt_next;
            drv_reg[sel]  <= drv_next;
            run_reg[sel]  <= run_next;
            pset_reg[sel] <= pset_next;
            dlev_reg[sel] <= dlev_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. A tick walks the motors one per cycle. A command is
    // applied in EXEC, after a trip through the divider when it needs a
    // new period. RESP waits for room in the result register.
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        have_next    = have_reg;
        tk_next      = tk_reg;
        events_next  = events_reg;
        div_start    = 1'b0;
        wr_en        = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    have_next   = 1'b0;
                    tk_next     = '0;
                    events_next = '0;
                    state_next  = (s_opcode == sppc_pkg::OP_TICK) ? ST_TICK : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (need_div && !have_reg) begin
                    div_start  = !div_status.busy;
                    state_next = ST_DIV;
                end else begin
                    wr_en      = mot_ok;
                    state_next = ST_RESP;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    have_next  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_TICK: begin
                wr_en               = 1'b1;
                events_next[tk_reg] = tick_event;
                if (tk_reg == MIW'(MOTOR_COUNT - 1)) begin
                    state_next = ST_RESP;
                end else begin
                    tk_next = tk_reg + MIW'(1);
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            have_reg    <= 1'b0;
            tk_reg      <= '0;
            events_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            have_reg    <= have_next;
            tk_reg      <= tk_next;
            events_reg  <= events_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Pin levels of all motors. The step pin is high while the timer
    // runs and the counter sits in the first half of the period.
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            steps_w[k] = run_reg[k] &&
                         (cnt_reg[k] < ((pset_reg[k] ? per_reg[k] : init_eff) >> 1));
        end
    end

    // Result register. The next beat may be taken while this one waits.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_motor_reg  <= mot_reg;
            m_pos_reg    <= mot_ok ? c_pos : '0;
            m_speed_reg  <= mot_ok ? c_vel : '0;
            m_mode_reg   <= mot_ok ? c_mode : sppc_pkg::MODE_IDLE;
            m_dir_reg    <= mot_ok ? c_dir : sppc_pkg::DIR_NONE;
            m_steps_reg  <= steps_w;
            m_dirs_reg   <= dlev_reg;
            m_ens_reg    <= ~drv_reg;
            m_events_reg <= events_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_report_motor = m_motor_reg;
    assign m_position     = m_pos_reg;
    assign m_speed        = m_speed_reg;
    assign m_mode         = m_mode_reg;
    assign m_direction    = m_dir_reg;
    assign m_step_pins    = m_steps_reg;
    assign m_dir_pins     = m_dirs_reg;
    assign m_enable_pins  = m_ens_reg;
    assign m_step_events  = m_events_reg;

endmodule

### hw/rtl/sppc_checker.sv
// Port-level checker for the stepper pulse/position controller, bound to the top level.
// Depends on sppc_pkg for field widths and mode/direction codes.
module sppc_checker #(
    parameter int MOTOR_COUNT = sppc_pkg::MOTOR_COUNT_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [sppc_pkg::MOTOR_W-1:0]      m_report_motor,
    input logic signed [sppc_pkg::POS_W-1:0] m_position,
    input logic signed [sppc_pkg::VEL_W-1:0] m_speed,
    input logic [sppc_pkg::MODE_W-1:0]       m_mode,
    input logic signed [sppc_pkg::DIR_W-1:0] m_direction,
    input logic [MOTOR_COUNT-1:0]            m_step_pins,
    input logic [MOTOR_COUNT-1:0]            m_dir_pins,
    input logic [MOTOR_COUNT-1:0]            m_enable_pins,
    input logic [MOTOR_COUNT-1:0]            m_step_events
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_report_motor) &&
        $stable(m_position) && $stable(m_speed) && $stable(m_mode) &&
        $stable(m_direction) && $stable(m_step_pins) && $stable(m_dir_pins) &&
        $stable(m_enable_pins) && $stable(m_step_events))
        else $error("result beat changed while stalled");

    // The block works on one beat at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command taken while the previous one is in work");

    // A motor that does not exist reports zero position, speed, mode and direction.
    a_absent_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ({2'b00, m_report_motor} >= 4'(MOTOR_COUNT)) |->
        (m_position == '0) && (m_speed == '0) &&
        (m_mode == sppc_pkg::MODE_IDLE) && (m_direction == sppc_pkg::DIR_NONE))
        else $error("absent motor reported a nonzero status");

    // A moving motor always has a direction.
    a_moving_has_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_mode == sppc_pkg::MODE_POS) || (m_mode == sppc_pkg::MODE_VEL)) |->
        (m_direction == sppc_pkg::DIR_FWD) || (m_direction == sppc_pkg::DIR_REV))
        else $error("running motor reported without a direction");

    // The direction pin of the reported motor agrees with its direction.
    a_dir_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ({2'b00, m_report_motor} < 4'(MOTOR_COUNT)) &&
        (m_direction != sppc_pkg::DIR_NONE) |->
        (m_dir_pins[m_report_motor] == (m_direction == sppc_pkg::DIR_FWD)))
        else $error("direction pin disagrees with reported direction");

endmodule

bind stepper_pulse_position_controller sppc_checker #(
    .MOTOR_COUNT (MOTOR_COUNT)
) u_sppc_checker (.*);

### sim/stepper_pulse_position_controller_tb.sv
// Self-checking testbench for the three-motor step/direction pulse controller.
// Depends on sppc_pkg and on the stepper_pulse_position_controller top level.
// A predictor in this file models the motors; it copies no code from the RTL.
module stepper_pulse_position_controller_tb;

    localparam int MOTORS         = sppc_pkg::MOTOR_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no beat on any channel
    localparam int SETTLE_CYCLES  = 40;     // longer than the divider path of a velocity beat
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASES         = 6;
    localparam int BEATS_PER_PHASE = 80;

    // The package names opcodes zero to six only. Seven must behave like a query.
    localparam logic [sppc_pkg::OP_W-1:0] OP_SPARE = 3'd7;
    localparam logic [sppc_pkg::PERIOD_BITS_DEF-1:0] PERIOD_CAP = '1;

    // One command beat as it travels on the s_ channel.
    typedef struct packed {
        logic [sppc_pkg::OP_W-1:0]         opcode;
        logic [sppc_pkg::MOTOR_W-1:0]      motor;
        logic signed [sppc_pkg::POS_W-1:0] target;
        logic signed [sppc_pkg::VEL_W-1:0] velocity;
        logic                              enable;
    } cmd_t;

    // One status beat as it travels on the m_ channel.
    typedef struct packed {
        logic [sppc_pkg::MOTOR_W-1:0]      motor;
        logic signed [sppc_pkg::POS_W-1:0] position;
        logic signed [sppc_pkg::VEL_W-1:0] speed;
        logic [sppc_pkg::MODE_W-1:0]       mode;
        logic signed [sppc_pkg::DIR_W-1:0] direction;
        logic [MOTORS-1:0]                 step_pins;
        logic [MOTORS-1:0]                 dir_pins;
        logic [MOTORS-1:0]                 enable_pins;
        logic [MOTORS-1:0]                 step_events;
    } status_t;

    // Every input starts at a known level so nothing is X before reset is released.
    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [sppc_pkg::CIDX_W-1:0]       cfg_index = '0;
    logic [sppc_pkg::CDAT_W-1:0]       cfg_data = '0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [sppc_pkg::OP_W-1:0]         s_opcode = '0;
    logic [sppc_pkg::MOTOR_W-1:0]      s_motor = '0;
    logic signed [sppc_pkg::POS_W-1:0] s_target_position = '0;
    logic signed [sppc_pkg::VEL_W-1:0] s_velocity = '0;
    logic                              s_enable_flag = 1'b0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [sppc_pkg::MOTOR_W-1:0]      m_report_motor;
    logic signed [sppc_pkg::POS_W-1:0] m_position;
    logic signed [sppc_pkg::VEL_W-1:0] m_speed;
    logic [sppc_pkg::MODE_W-1:0]       m_mode;
    logic signed [sppc_pkg::DIR_W-1:0] m_direction;
    logic [MOTORS-1:0]                 m_step_pins;
    logic [MOTORS-1:0]                 m_dir_pins;
    logic [MOTORS-1:0]                 m_enable_pins;
    logic [MOTORS-1:0]                 m_step_events;

    stepper_pulse_position_controller u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_motor           (s_motor),
        .s_target_position (s_target_position),
        .s_velocity        (s_velocity),
        .s_enable_flag     (s_enable_flag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_motor    (m_report_motor),
        .m_position        (m_position),
        .m_speed           (m_speed),
        .m_mode            (m_mode),
        .m_direction       (m_direction),
        .m_step_pins       (m_step_pins),
        .m_dir_pins        (m_dir_pins),
        .m_enable_pins     (m_enable_pins),
        .m_step_events     (m_step_events)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Motor predictor. It holds its own copy of the configuration and of
    // every motor's state, and is advanced once per accepted command beat.
    // ------------------------------------------------------------------
    logic [sppc_pkg::RATE_W-1:0]          rate_cfg;
    logic [sppc_pkg::IPER_W-1:0]          iper_cfg;
    logic [sppc_pkg::POS_W-1:0]           pos_r        [MOTORS];
    logic [sppc_pkg::POS_W-1:0]           goal_r       [MOTORS];
    logic signed [sppc_pkg::VEL_W-1:0]    vel_r        [MOTORS];
    logic [sppc_pkg::MODE_W-1:0]          mode_r       [MOTORS];
    logic [sppc_pkg::DIR_W-1:0]           dir_r        [MOTORS];
    logic                                 drv_en       [MOTORS];
    logic                                 running      [MOTORS];
    logic                                 period_known [MOTORS];
    logic [sppc_pkg::PERIOD_BITS_DEF-1:0] period_r     [MOTORS];
    logic [sppc_pkg::PERIOD_BITS_DEF-1:0] count_r      [MOTORS];
    logic                                 dir_pin      [MOTORS];

    cmd_t    pending_cmds[$];      // command beats waiting for the driver
    status_t expected_status[$];   // status beats predicted but not yet seen

    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int status_beats = 0;
    int quiet_cycles = 0;

    function automatic void clear_model();
        rate_cfg = sppc_pkg::TICK_RATE_RST;
        iper_cfg = sppc_pkg::INIT_PERIOD_RST;
        for (int k = 0; k < MOTORS; k++) begin
            pos_r[k] = '0;
            goal_r[k] = '0;
            vel_r[k] = '0;
            mode_r[k] = sppc_pkg::MODE_IDLE;
            dir_r[k] = sppc_pkg::DIR_FWD;
            drv_en[k] = 1'b0;
            running[k] = 1'b0;
            period_known[k] = 1'b0;
            period_r[k] = '0;
            count_r[k] = '0;
            dir_pin[k] = 1'b1;
        end
    endfunction

    // A motor that no velocity command has touched follows the live
    // initial_period register, so a later write changes its pace.
    function automatic logic [sppc_pkg::PERIOD_BITS_DEF-1:0] eff_period(int k);
        return period_known[k] ? period_r[k] : iper_cfg;
    endfunction

    // Ticks between steps: floor(rate/|v|) - 1, zero when the quotient is
    // zero and saturated at the counter width.
    function automatic logic [sppc_pkg::PERIOD_BITS_DEF-1:0] period_for(
            logic signed [sppc_pkg::VEL_W-1:0] v);
        logic [sppc_pkg::VEL_W-1:0]  mag;
        logic [sppc_pkg::RATE_W-1:0] quot;
        mag = v[sppc_pkg::VEL_W-1] ? (~v + 1'b1) : v;
        quot = rate_cfg / {{(sppc_pkg::RATE_W-sppc_pkg::VEL_W){1'b0}}, mag};
        if (quot == '0)
            return '0;
        if (quot - 1'b1 > sppc_pkg::RATE_W'(PERIOD_CAP))
            return PERIOD_CAP;
        return sppc_pkg::PERIOD_BITS_DEF'(quot - 1'b1);
    endfunction

    // The direction pin follows only real directions; a stop leaves it alone.
    function automatic void point_dir(int k, logic fwd);
        dir_r[k] = fwd ? sppc_pkg::DIR_FWD : sppc_pkg::DIR_REV;
        dir_pin[k] = fwd;
    endfunction

    function automatic void aim_at_goal(int k);
        point_dir(k, $signed(goal_r[k]) > $signed(pos_r[k]));
        running[k] = 1'b1;
        mode_r[k] = sppc_pkg::MODE_POS;
    endfunction

    function automatic void set_speed(int k, logic signed [sppc_pkg::VEL_W-1:0] v);
        drv_en[k] = 1'b1;
        vel_r[k] = v;
        if (v == '0) begin
            mode_r[k] = sppc_pkg::MODE_IDLE;
            dir_r[k] = sppc_pkg::DIR_NONE;
            running[k] = 1'b0;
            return;
        end
        point_dir(k, !v[sppc_pkg::VEL_W-1]);
        mode_r[k] = sppc_pkg::MODE_VEL;
        period_r[k] = period_for(v);
        period_known[k] = 1'b1;
        running[k] = 1'b1;
    endfunction

    // One time-base tick for one motor; returns whether the counter wrapped.
    // A counter already past the period wraps just as if it had reached it.
    function automatic logic tick_one(int k);
        logic [sppc_pkg::PERIOD_BITS_DEF-1:0] lim;
        lim = eff_period(k);
        if (!running[k])
            return 1'b0;
        if (count_r[k] < lim) begin
            count_r[k] = count_r[k] + 1'b1;
            return 1'b0;
        end
        count_r[k] = '0;
        pos_r[k] = pos_r[k] + {{(sppc_pkg::POS_W-sppc_pkg::DIR_W){dir_r[k][sppc_pkg::DIR_W-1]}},
                               dir_r[k]};
        if (mode_r[k] == sppc_pkg::MODE_POS && pos_r[k] == goal_r[k]) begin
            running[k] = 1'b0;
            mode_r[k] = sppc_pkg::MODE_IDLE;
        end
        // Overshoot in position mode turns the motor around.
        if (mode_r[k] == sppc_pkg::MODE_POS && dir_r[k] == sppc_pkg::DIR_FWD
                && $signed(pos_r[k]) > $signed(goal_r[k]))
            point_dir(k, 1'b0);
        if (mode_r[k] == sppc_pkg::MODE_POS && dir_r[k] == sppc_pkg::DIR_REV
                && $signed(pos_r[k]) < $signed(goal_r[k]))
            point_dir(k, 1'b1);
        return 1'b1;
    endfunction

    // Applies one command beat and returns the status beat it must produce.
    function automatic status_t apply_beat(cmd_t c);
        status_t st;
        int      m;
        logic    hit;
        st = '0;
        m = int'(c.motor);
        hit = (m < MOTORS);
        if (c.opcode == sppc_pkg::OP_TICK) begin
            // A tick drives every motor whatever its motor field says.
            for (int k = 0; k < MOTORS; k++)
                st.step_events[k] = tick_one(k);
        end else if (hit) begin
            case (c.opcode)
                sppc_pkg::OP_SET_POS: begin
                    drv_en[m] = 1'b1;
                    goal_r[m] = c.target;
                    if (c.target != pos_r[m])
                        aim_at_goal(m);
                end
                sppc_pkg::OP_SET_PV: begin
                    // With a nonzero velocity, a target equal to the position keeps period, direction and mode.
                    drv_en[m] = 1'b1;
                    vel_r[m] = c.velocity;
                    goal_r[m] = c.target;
                    if (c.velocity == '0) begin
                        set_speed(m, '0);
                    end else if (c.target != pos_r[m]) begin
                        period_r[m] = period_for(c.velocity);
                        period_known[m] = 1'b1;
                        aim_at_goal(m);
                    end
                end
                sppc_pkg::OP_SET_VEL: set_speed(m, c.velocity);
                sppc_pkg::OP_ZERO: begin
                    set_speed(m, '0);
                    pos_r[m] = '0;
                end
                // Disabling clears only the enable pin; stepping goes on.
                sppc_pkg::OP_ENABLE: drv_en[m] = c.enable;
                default: ;   // query and the spare opcode change nothing
            endcase
        end
        for (int k = 0; k < MOTORS; k++) begin
            st.step_pins[k] = running[k] && (count_r[k] < (eff_period(k) >> 1));
            st.dir_pins[k] = dir_pin[k];
            st.enable_pins[k] = !drv_en[k];
        end
        st.motor = c.motor;
        if (hit) begin
            st.position = pos_r[m];
            st.speed = vel_r[m];
            st.mode = mode_r[m];
            st.direction = dir_r[m];
        end
        return st;
    endfunction

    function automatic string describe(status_t s);
        return $sformatf("motor %0d pos %0d speed %0d mode %0d dir %0d step %b dir %b en %b ev %b",
                         s.motor, s.position, s.speed, s.mode, s.direction,
                         s.step_pins, s.dir_pins, s.enable_pins, s.step_events);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic cmd_t make_cmd(logic [sppc_pkg::OP_W-1:0] op,
                                      logic [sppc_pkg::MOTOR_W-1:0] m,
                                      logic signed [sppc_pkg::POS_W-1:0] tgt,
                                      logic signed [sppc_pkg::VEL_W-1:0] v, logic en);
        cmd_t c;
        c.opcode = op;
        c.motor = m;
        c.target = tgt;
        c.velocity = v;
        c.enable = en;
        return c;
    endfunction

    // Random command. Half the beats are ticks so that motors really step,
    // velocities mostly give short periods at the current tick rate, and
    // targets mostly lie a few pulses from where the motor stands, so that
    // goals are reached, overshot and reversed within the run.
    function automatic cmd_t roll_command();
        cmd_t                        c;
        int unsigned                 r;
        logic [sppc_pkg::RATE_W-1:0] raw;
        logic [sppc_pkg::VEL_W-1:0]  mag;
        logic [sppc_pkg::POS_W-1:0]  here;
        r = $urandom_range(99);
        if (r < 50)      c.opcode = sppc_pkg::OP_TICK;
        else if (r < 60) c.opcode = sppc_pkg::OP_SET_POS;
        else if (r < 70) c.opcode = sppc_pkg::OP_SET_PV;
        else if (r < 80) c.opcode = sppc_pkg::OP_SET_VEL;
        else if (r < 85) c.opcode = sppc_pkg::OP_ZERO;
        else if (r < 92) c.opcode = sppc_pkg::OP_ENABLE;
        else if (r < 97) c.opcode = sppc_pkg::OP_QUERY;
        else             c.opcode = OP_SPARE;
        // Now and then address the motor slot that does not exist.
        c.motor = ($urandom_range(99) < 6) ? sppc_pkg::MOTOR_W'(MOTORS)
                                           : sppc_pkg::MOTOR_W'($urandom_range(MOTORS - 1));
        c.enable = 1'($urandom_range(1));

        r = $urandom_range(99);
        if (r < 10) begin
            mag = '0;
        end else if (r < 55) begin
            raw = rate_cfg / sppc_pkg::RATE_W'($urandom_range(1, 8));
            if (raw == '0)
                raw = sppc_pkg::RATE_W'(1);
            mag = (raw > sppc_pkg::RATE_W'(21'h0FFFFF)) ? 21'h0FFFFF
                                                       : sppc_pkg::VEL_W'(raw);
        end else if (r < 65) begin
            mag = 21'h0FFFFF;
        end else if (r < 80) begin
            mag = sppc_pkg::VEL_W'($urandom_range(1, 21'h0FFFFF));
        end else begin
            mag = sppc_pkg::VEL_W'($urandom_range(1, 16));
        end
        c.velocity = $urandom_range(1) ? -$signed(mag) : $signed(mag);

        here = pos_r[(int'(c.motor) < MOTORS) ? int'(c.motor) : 0];
        r = $urandom_range(99);
        if (r < 55) begin
            c.target = here + sppc_pkg::POS_W'($urandom_range(8)) - sppc_pkg::POS_W'(4);
        end else if (r < 65) begin
            c.target = here;
        end else if (r < 75) begin
            case ($urandom_range(3))
                0: c.target = 32'sh7FFFFFFF;
                1: c.target = 32'sh80000000;
                2: c.target = '0;
                default: c.target = -32'sd1;
            endcase
        end else begin
            c.target = $urandom();
        end
        return c;
    endfunction

    // Holds until the driver has nothing left and every status beat is in.
    task automatic wait_quiet();
        do
            @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_status.size() != 0);
    endtask

    // Only called while the block is idle. The predictor takes the new value
    // at the edge where the write handshake completes.
    task automatic write_reg(logic [sppc_pkg::CIDX_W-1:0] idx,
                             logic [sppc_pkg::CDAT_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sppc_pkg::CFG_TICK_RATE)
            rate_cfg = val;
        else if (idx == sppc_pkg::CFG_INIT_PERIOD)
            iper_cfg = val[sppc_pkg::IPER_W-1:0];
    endtask

    task automatic set_idling(int sel);
        case (sel % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 73; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Command driver. When the current beat is taken, or the channel is
    // empty, it may load the next pending beat, unless it decides to idle.
    // Valid is assigned once per edge, so a back-to-back beat keeps it high.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_status.push_back(apply_beat(make_cmd(s_opcode, s_motor,
                    s_target_position, s_velocity, s_enable_flag)));
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_t nxt;
                    nxt = pending_cmds.pop_front();
                    s_opcode <= nxt.opcode;
                    s_motor <= nxt.motor;
                    s_target_position <= nxt.target;
                    s_velocity <= nxt.velocity;
                    s_enable_flag <= nxt.enable;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Status monitor. Every status beat is matched against the oldest
    // prediction; ready is thrown at random according to the stall rate.
    // ------------------------------------------------------------------
    status_t got_status, want_status;
    string   bad_fields;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                status_beats = status_beats + 1;
                got_status = '{motor: m_report_motor, position: m_position, speed: m_speed,
                               mode: m_mode, direction: m_direction, step_pins: m_step_pins,
                               dir_pins: m_dir_pins, enable_pins: m_enable_pins,
                               step_events: m_step_events};
                if (expected_status.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                        $display("status beat %0d arrived with none expected: %s",
                                 status_beats, describe(got_status));
                end else begin
                    want_status = expected_status.pop_front();
                    bad_fields = "";
                    if (got_status.motor !== want_status.motor)
                        bad_fields = {bad_fields, " report_motor"};
                    if (got_status.position !== want_status.position)
                        bad_fields = {bad_fields, " position"};
                    if (got_status.speed !== want_status.speed)
                        bad_fields = {bad_fields, " speed"};
                    if (got_status.mode !== want_status.mode)
                        bad_fields = {bad_fields, " mode"};
                    if (got_status.direction !== want_status.direction)
                        bad_fields = {bad_fields, " direction"};
                    if (got_status.step_pins !== want_status.step_pins)
                        bad_fields = {bad_fields, " step_pins"};
                    if (got_status.dir_pins !== want_status.dir_pins)
                        bad_fields = {bad_fields, " dir_pins"};
                    if (got_status.enable_pins !== want_status.enable_pins)
                        bad_fields = {bad_fields, " enable_pins"};
                    if (got_status.step_events !== want_status.step_events)
                        bad_fields = {bad_fields, " step_events"};
                    if (bad_fields != "") begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("status beat %0d differs in%s", status_beats, bad_fields);
                            $display("  expected %s", describe(want_status));
                            $display("  received %s", describe(got_status));
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a run in which no channel moves a beat for too long is hung.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    logic [sppc_pkg::RATE_W-1:0] rate_plan [PHASES];
    logic [sppc_pkg::IPER_W-1:0] iper_plan [PHASES];

    initial begin
        clear_model();
        // Tick rates and initial periods per phase: both ends of each register,
        // a slow and a fast time base, and two random settings.
        rate_plan = '{24'd16, 24'd1, 24'hFFFFFF, 24'd1000000, 24'd0, 24'd0};
        iper_plan = '{16'd0, 16'd0, 16'hFFFF, 16'd3, 16'd0, 16'd0};
        rate_plan[4] = sppc_pkg::RATE_W'($urandom_range(2, 64));
        iper_plan[4] = sppc_pkg::IPER_W'($urandom_range(0, 8));
        rate_plan[5] = sppc_pkg::RATE_W'($urandom_range(1, 24'hFFFFFF));
        iper_plan[5] = sppc_pkg::IPER_W'($urandom_range(0, 16'hFFFF));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset configuration: reset status, the spare
        // opcode, enable and disable, a period of zero from a quotient of zero,
        // a saturated period, the nonexistent motor, a stop through velocity
        // zero, the position extremes, and a handful of ticks to see steps.
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_QUERY,   2'd0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_SPARE,             2'd1, -32'sd1, -21'sd1, 1'b1));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_ENABLE,  2'd2, '0, '0, 1'b1));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_ENABLE,  2'd2, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_VEL, 2'd0, '0, 21'sd500000, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_VEL, 2'd1, '0, -21'sd1048575, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_PV,  2'd2, 32'sd2, 21'sd1000000,
                                        1'b0));
        repeat (6)
            pending_cmds.push_back(make_cmd(sppc_pkg::OP_TICK, 2'd0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_VEL, 2'd1, '0, 21'sd1, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_TICK,    2'd2, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_ZERO,    2'd0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_VEL, sppc_pkg::MOTOR_W'(MOTORS),
                                        '0, 21'sd7, 1'b1));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_TICK,    sppc_pkg::MOTOR_W'(MOTORS),
                                        '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_PV,  2'd2, 32'sd5, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_POS, 2'd1, 32'sh7FFFFFFF, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_POS, 2'd0, 32'sh80000000, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_TICK,    2'd0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_TICK,    2'd0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_QUERY,   2'd1, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(sppc_pkg::OP_SET_PV,  2'd0, 32'sh80000000,
                                        -21'sd1048575, 1'b1));

        // Random part. Each phase starts from an idle block with a new setting;
        // the idling pattern changes every twenty beats, and halfway through
        // each phase the sender holds off until every status beat is back.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_quiet();
            write_reg(sppc_pkg::CFG_TICK_RATE, rate_plan[ph]);
            write_reg(sppc_pkg::CFG_INIT_PERIOD,
                      {{(sppc_pkg::CDAT_W-sppc_pkg::IPER_W){1'b0}}, iper_plan[ph]});
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n % 20 == 0)
                    set_idling(ph + n / 20);
                if (n == BEATS_PER_PHASE / 2)
                    wait_quiet();
                // Keep the backlog short so targets are drawn near the
                // positions the motors actually hold.
                do
                    @(negedge aclk);
                while (pending_cmds.size() >= 2);
                pending_cmds.push_back(roll_command());
            end
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/sppc_pkg.sv
hw/rtl/sppc_period_div.sv
hw/rtl/stepper_pulse_position_controller.sv
hw/rtl/sppc_checker.sv
sim/stepper_pulse_position_controller_tb.sv
